>>> src/rgbaps_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// RGB activity pulse scheduler: shared package
// Word types, register indexes, slot constants and the colour table.
// ============================================================================
package rgbaps_pkg;

    localparam int          MS_W       = 16;
    localparam int          US_W       = 26;
    localparam int          COLOUR_W   = 3;
    localparam int          SLOT_W     = 4;
    localparam int          NUM_COLOUR = 8;
    localparam int          CFG_IDX_W  = 2;
    localparam int          CFG_DATA_W = 16;

    localparam logic [SLOT_W-1:0] IDLE_SLOT = 4'd8;
    localparam logic [SLOT_W:0]   NUM_SLOTS = 5'd9;
    localparam logic [9:0]        US_PER_MS = 10'd1000;

    localparam logic [US_W-1:0]     RST_PULSE_US  = 26'd50000;
    localparam logic [US_W-1:0]     RST_IDLE_US   = 26'd50000;
    localparam logic [COLOUR_W-1:0] RST_IDLE_COL  = 3'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PULSE_MS    = 2'd0,
        REG_IDLE_GAP_MS = 2'd1,
        REG_IDLE_COLOR  = 2'd2,
        REG_ON_LEVEL    = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic                pulse_req;
        logic [COLOUR_W-1:0] pulse_color;
    } req_t;

    typedef struct packed {
        logic              pin_red;
        logic              pin_green;
        logic              pin_blue;
        logic              changed;
        logic [SLOT_W-1:0] active_slot;
    } res_t;

    typedef struct packed {
        logic [US_W-1:0]     pulse_us;
        logic [US_W-1:0]     idle_us;
        logic [COLOUR_W-1:0] idle_color;
        logic                on_level;
        logic                idle_write;
    } cfg_t;

    // channel bits: bit 0 red, bit 1 green, bit 2 blue
    function automatic logic [2:0] colour_rgb(input logic [COLOUR_W-1:0] colour);
        logic [2:0] rgb;
        unique case (colour)
            3'd0:    rgb = 3'b000;
            3'd1:    rgb = 3'b001;
            3'd2:    rgb = 3'b010;
            3'd3:    rgb = 3'b100;
            3'd4:    rgb = 3'b011;
            3'd5:    rgb = 3'b110;
            3'd6:    rgb = 3'b101;
            default: rgb = 3'b111;
        endcase
        return rgb;
    endfunction

    function automatic logic [US_W-1:0] ms_to_us(input logic [MS_W-1:0] ms);
        return US_W'(ms) * US_W'(US_PER_MS);
    endfunction

endpackage

>>> src/rgbaps_cfg.sv
`timescale 1ns / 1ps
// ============================================================================
// RGB activity pulse scheduler: configuration registers
// Holds slot lengths (kept in microseconds), idle colour and pin polarity.
// ============================================================================
module rgbaps_cfg
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [rgbaps_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rgbaps_pkg::CFG_DATA_W-1:0]    cfg_data,
    output rgbaps_pkg::cfg_t                     cfg
);

    logic [rgbaps_pkg::US_W-1:0]     pulse_us_reg,   pulse_us_next;
    logic [rgbaps_pkg::US_W-1:0]     idle_us_reg,    idle_us_next;
    logic [rgbaps_pkg::COLOUR_W-1:0] idle_color_reg, idle_color_next;
    logic                            on_level_reg,   on_level_next;
    rgbaps_pkg::reg_idx_t            idx;

    always_comb
    begin
        idx             = rgbaps_pkg::reg_idx_t'(cfg_index);
        pulse_us_next   = pulse_us_reg;
        idle_us_next    = idle_us_reg;
        idle_color_next = idle_color_reg;
        on_level_next   = on_level_reg;
        if (cfg_we)
        begin
            unique case (idx)
                rgbaps_pkg::REG_PULSE_MS:
                    pulse_us_next = rgbaps_pkg::ms_to_us(cfg_data);
                rgbaps_pkg::REG_IDLE_GAP_MS:
                    idle_us_next = rgbaps_pkg::ms_to_us(cfg_data);
                rgbaps_pkg::REG_IDLE_COLOR:
                    idle_color_next = cfg_data[rgbaps_pkg::COLOUR_W-1:0];
                rgbaps_pkg::REG_ON_LEVEL:
                    on_level_next = cfg_data[0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_us_reg   <= rgbaps_pkg::RST_PULSE_US;
            idle_us_reg    <= rgbaps_pkg::RST_IDLE_US;
            idle_color_reg <= rgbaps_pkg::RST_IDLE_COL;
            on_level_reg   <= 1'b1;
        end
        else
        begin
            pulse_us_reg   <= pulse_us_next;
            idle_us_reg    <= idle_us_next;
            idle_color_reg <= idle_color_next;
            on_level_reg   <= on_level_next;
        end
    end

    assign cfg.pulse_us   = pulse_us_reg;
    assign cfg.idle_us    = idle_us_reg;
    assign cfg.idle_color = idle_color_reg;
    assign cfg.on_level   = on_level_reg;
    assign cfg.idle_write = cfg_we && (idx == rgbaps_pkg::REG_IDLE_COLOR);

endmodule

>>> src/rgbaps_core.sv
`timescale 1ns / 1ps
// ============================================================================
// RGB activity pulse scheduler: slot engine
// Pending bits, slot countdown and the round-robin search over nine slots.
// ============================================================================
module rgbaps_core
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  rgbaps_pkg::req_t req,
    input  rgbaps_pkg::cfg_t cfg,
    output rgbaps_pkg::res_t res
);

    logic [rgbaps_pkg::NUM_COLOUR-1:0] pending_reg,      pending_next;
    logic [rgbaps_pkg::SLOT_W-1:0]     cur_slot_reg,     cur_slot_next;
    logic [rgbaps_pkg::US_W-1:0]       remaining_reg,    remaining_next;
    logic                              needs_update_reg, needs_update_next;
    logic [rgbaps_pkg::COLOUR_W-1:0]   shown_color_reg,  shown_color_next;

    logic                              hit;
    logic [rgbaps_pkg::NUM_COLOUR-1:0] pend_set;
    logic                              nu_set;
    logic [rgbaps_pkg::US_W-1:0]       rem_dec;
    logic                              run_search;
    logic                              found;
    logic [rgbaps_pkg::SLOT_W:0]       cand;
    logic [rgbaps_pkg::SLOT_W-1:0]     pick;
    logic [rgbaps_pkg::NUM_COLOUR-1:0] step_pending;
    logic [rgbaps_pkg::SLOT_W-1:0]     step_slot;
    logic [rgbaps_pkg::US_W-1:0]       step_remaining;
    logic                              step_nu;
    logic [rgbaps_pkg::COLOUR_W-1:0]   step_shown;
    logic [2:0]                        rgb;

    // round-robin pick: first pending slot after the current one, idle always pending
    always_comb
    begin
        found = 1'b0;
        pick  = rgbaps_pkg::IDLE_SLOT;
        cand  = '0;
        for (int k = 1; k <= 9; k++)
        begin
            cand = {1'b0, cur_slot_reg} + 5'(k);
            if (cand >= rgbaps_pkg::NUM_SLOTS)
            begin
                cand = cand - rgbaps_pkg::NUM_SLOTS;
            end
            if (!found && ((cand[rgbaps_pkg::SLOT_W-1:0] == rgbaps_pkg::IDLE_SLOT)
                           || pend_set[cand[2:0]]))
            begin
                found = 1'b1;
                pick  = cand[rgbaps_pkg::SLOT_W-1:0];
            end
        end
    end

    always_comb
    begin
        hit      = req.pulse_req && (req.pulse_color != cfg.idle_color);
        pend_set = pending_reg | (hit ? (8'b1 << req.pulse_color) : 8'b0);
        nu_set   = needs_update_reg | hit | cfg.idle_write;
        rem_dec  = (remaining_reg != '0) ? remaining_reg - 26'd1 : remaining_reg;
        run_search = (rem_dec == '0)
                     && !((cur_slot_reg == rgbaps_pkg::IDLE_SLOT) && !nu_set);

        step_pending   = pend_set;
        step_slot      = cur_slot_reg;
        step_remaining = rem_dec;
        step_nu        = nu_set;
        step_shown     = shown_color_reg;
        if (run_search)
        begin
            step_slot = pick;
            if (pick != rgbaps_pkg::IDLE_SLOT)
            begin
                step_pending   = pend_set & ~(8'b1 << pick[2:0]);
                step_shown     = pick[2:0];
                step_remaining = cfg.pulse_us;
            end
            else
            begin
                if (cur_slot_reg == rgbaps_pkg::IDLE_SLOT)
                begin
                    step_nu = 1'b0;
                end
                step_shown     = cfg.idle_color;
                step_remaining = cfg.idle_us;
            end
        end

        if (accept)
        begin
            pending_next      = step_pending;
            cur_slot_next     = step_slot;
            remaining_next    = step_remaining;
            needs_update_next = step_nu;
            shown_color_next  = step_shown;
        end
        else
        begin
            pending_next      = pending_reg;
            cur_slot_next     = cur_slot_reg;
            remaining_next    = remaining_reg;
            needs_update_next = needs_update_reg | cfg.idle_write;
            shown_color_next  = shown_color_reg;
        end

        rgb = rgbaps_pkg::colour_rgb(step_shown) ^ {3{~cfg.on_level}};
        res.pin_red     = rgb[0];
        res.pin_green   = rgb[1];
        res.pin_blue    = rgb[2];
        res.changed     = run_search;
        res.active_slot = step_slot;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg      <= '0;
            cur_slot_reg     <= rgbaps_pkg::IDLE_SLOT;
            remaining_reg    <= '0;
            needs_update_reg <= 1'b1;
            shown_color_reg  <= '0;
        end
        else
        begin
            pending_reg      <= pending_next;
            cur_slot_reg     <= cur_slot_next;
            remaining_reg    <= remaining_next;
            needs_update_reg <= needs_update_next;
            shown_color_reg  <= shown_color_next;
        end
    end

endmodule

>>> src/rgb_activity_pulse_scheduler_top.sv
`timescale 1ns / 1ps
// ============================================================================
// RGB activity pulse scheduler: top level
// Takes one tick word per microsecond and returns one pin word per tick.
// ============================================================================
// Each accepted tick word yields exactly one result word in the next cycle; a
// new tick word is taken in every cycle while the result register is empty or
// being drained. Throughput is one word per clock while the far side does not
// stall, as the countdown and nine-slot round-robin search in the slot engine
// are combinational. Slot lengths are converted to microseconds when written,
// so a new length applies from the next slot loaded after the write.
module rgb_activity_pulse_scheduler_top
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  rgbaps_pkg::req_t                  req_word,
    output logic                              res_valid,
    input  logic                              res_stall,
    output rgbaps_pkg::res_t                  res_word,
    input  logic                              cfg_we,
    input  logic [rgbaps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rgbaps_pkg::CFG_DATA_W-1:0] cfg_data
);

    rgbaps_pkg::cfg_t cfg;
    rgbaps_pkg::res_t res_step;
    logic             accept;
    logic             res_valid_reg, res_valid_next;
    rgbaps_pkg::res_t res_word_reg,  res_word_next;

    rgbaps_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rgbaps_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .req    (req_word),
        .cfg    (cfg),
        .res    (res_step)
    );

    // hold the result word while the far side stalls
    assign req_stall = res_valid_reg && res_stall;
    assign accept    = req_valid && !req_stall;

    always_comb
    begin
        res_valid_next = accept || (res_valid_reg && res_stall);
        res_word_next  = accept ? res_step : res_word_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_word_reg <= res_word_next;
    end

    assign res_valid = res_valid_reg;
    assign res_word  = res_word_reg;

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> (res_valid && res_stall))
        else $error("input stalled without a held result word");

    a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_word.active_slot <= rgbaps_pkg::IDLE_SLOT))
        else $error("active slot out of range");

    a_colour_start_pins: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && res_step.changed && (res_step.active_slot != rgbaps_pkg::IDLE_SLOT))
        |-> ({res_step.pin_blue, res_step.pin_green, res_step.pin_red} ==
             (rgbaps_pkg::colour_rgb(res_step.active_slot[2:0]) ^ {3{~cfg.on_level}})))
        else $error("colour slot started with wrong pin levels");

endmodule
